// ===== hdl/tmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer queue package
// Shared constants, codes, state type and the result word layout.
// ----------------------------------------------------------------------------
package tmq_pkg;

	localparam int HEAP_CAPACITY_DEF = 32;
	localparam int ID_SLOTS_DEF      = 1024;
	localparam int TIME_BITS_DEF     = 48;

	localparam int ID_W   = 10;
	localparam int TMO_W  = 31;
	localparam int NOW_W  = 48;
	localparam int NEXT_W = 32;

	typedef enum logic [2:0] {
		MODE_ADD    = 3'd0,
		MODE_ADJUST = 3'd1,
		MODE_FIRE   = 3'd2,
		MODE_DROP   = 3'd3,
		MODE_TICK   = 3'd4,
		MODE_CLEAR  = 3'd5,
		MODE_QUERY  = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_NOID = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LOOK, S_CHK, S_FIRE, S_RM0, S_RM1,
		S_DN0, S_DN1, S_DN2, S_DN3, S_UP0, S_UP1, S_TK0, S_TK1, S_FIN
	} state_t;

	typedef struct packed {
		logic               kind;
		logic [ID_W-1:0]    fired_id;
		logic [NEXT_W-1:0]  next_tick_ms;
		status_t            status;
		logic               last;
	} res_t;

endpackage

// ===== hdl/tmq_out_slice.sv =====
// ----------------------------------------------------------------------------
// Timer queue output register
// Holds one result word so the engine can move on while it waits.
// ----------------------------------------------------------------------------
module tmq_out_slice
	import tmq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	logic valid_q;
	res_t data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

endmodule

// ===== hdl/min_heap_timer_queue.sv =====
// ----------------------------------------------------------------------------
// Min-heap timer queue
// Timers kept as a binary min-heap on expiry time with an id-to-slot map.
// ----------------------------------------------------------------------------
// Usage: each input word on the s_ group carries a mode in s_tuser and the
// timer id, timeout and current time in s_tdata. The block answers with one
// or more result words on the m_ group. A fire, tick or query first emits one
// fired word per timer it ends, earliest first; every input word then ends with
// exactly one status word, marked by m_tlast, which carries the status code
// and, for a query, the time until the next expiry (-1 when empty).
// Each item moves its entry one heap level at a time, and each timer that
// fires costs one removal pass. The heap memory has one write port and one
// registered read port, each used at most once per cycle.
// After reset the block sweeps the id map once, one entry per cycle;
// s_tready stays low until the sweep ends. A stalled receiver holds the
// engine at its next result; the output register lets the final status
// word wait while the next input word is accepted.
// ----------------------------------------------------------------------------
module min_heap_timer_queue
	import tmq_pkg::*;
#(
	parameter int HEAP_CAPACITY = HEAP_CAPACITY_DEF,
	parameter int ID_SLOTS      = ID_SLOTS_DEF,
	parameter int TIME_BITS     = TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // timer_id[9:0], timeout_ms[40:10], now_ms[88:41], zero fill
	input  logic [2:0]  s_tuser,  // mode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // fired_id[9:0], next_tick_ms[41:10], status[43:42], zero fill
	output logic        m_tuser,  // kind[0]
	output logic        m_tlast
);

	localparam int SW = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
	localparam int CW = $clog2(HEAP_CAPACITY + 1);
	localparam int XW = SW + 2;
	localparam int IW = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
	localparam int TB = TIME_BITS;
	localparam int EW = TB + ID_W;

	// Heap word: expiry in the upper bits, id in the lower bits.
	logic [EW-1:0] heap_mem [HEAP_CAPACITY];
	logic [SW-1:0] slot_mem [ID_SLOTS];

	logic [EW-1:0] heap_rd_q;
	logic [SW-1:0] slot_rd_q;
	logic          heap_re, heap_we, slot_re, slot_we;
	logic [SW-1:0] heap_raddr, heap_waddr, slot_wdata;
	logic [EW-1:0] heap_wdata;
	logic [IW-1:0] slot_raddr, slot_waddr;

	state_t           state_q, state_d;
	mode_t            mode_q, mode_d;
	logic [ID_W-1:0]  id_q, id_d;
	logic [TB-1:0]    exp_q, exp_d, now_q, now_d;
	logic             in_range_q, in_range_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [SW-1:0]    hole_q, hole_d, ch_idx_q, ch_idx_d;
	logic [ID_W-1:0]  e_id_q, e_id_d, ch_id_q, ch_id_d;
	logic [TB-1:0]    e_exp_q, e_exp_d, ch_exp_q, ch_exp_d;
	logic             first_q, first_d;
	status_t          status_q, status_d;
	logic [NEXT_W-1:0] next_q, next_d;
	logic [IW-1:0]    clr_q, clr_d;

	logic             res_valid, res_ready;
	res_t             res, out_res;

	// Input word fields and the saturating expiry sum.
	logic [ID_W-1:0]     in_id;
	logic [TMO_W-1:0]    in_tmo;
	logic [NOW_W-1:0]    in_now;
	logic [NOW_W+TB-1:0] now_wide;
	logic [TB-1:0]       now_sat;
	logic [TB:0]         exp_sum;
	logic [TB-1:0]       in_exp;

	assign in_id    = s_tdata[9:0];
	assign in_tmo   = s_tdata[40:10];
	assign in_now   = s_tdata[88:41];
	assign now_wide = (NOW_W+TB)'(in_now);
	assign now_sat  = (now_wide > {{NOW_W{1'b0}}, {TB{1'b1}}}) ? {TB{1'b1}} : now_wide[TB-1:0];
	assign exp_sum  = {1'b0, now_sat} + (TB+1)'(in_tmo);
	assign in_exp   = exp_sum[TB] ? {TB{1'b1}} : exp_sum[TB-1:0];

	logic [ID_W-1:0] rd_id;
	logic [TB-1:0]   rd_exp, diff;
	logic [XW-1:0]   child_l, child_r, cnt_x;
	logic [SW-1:0]   parent;
	logic [CW-1:0]   last_slot;
	logic            present, tick_mode;

	assign rd_id     = heap_rd_q[ID_W-1:0];
	assign rd_exp    = heap_rd_q[EW-1:ID_W];
	assign child_l   = XW'({hole_q, 1'b1});
	assign child_r   = child_l + XW'(1);
	assign cnt_x     = XW'(cnt_q);
	assign parent    = SW'((hole_q - SW'(1)) >> 1);
	assign last_slot = cnt_q - CW'(1);
	assign diff      = rd_exp - now_q;
	assign present   = in_range_q && (CW'(hole_q) < cnt_q) && (rd_id == id_q);
	assign tick_mode = mode_q inside {MODE_TICK, MODE_QUERY};

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		id_d       = id_q;
		exp_d      = exp_q;
		now_d      = now_q;
		in_range_d = in_range_q;
		cnt_d      = cnt_q;
		hole_d     = hole_q;
		ch_idx_d   = ch_idx_q;
		e_id_d     = e_id_q;
		e_exp_d    = e_exp_q;
		ch_id_d    = ch_id_q;
		ch_exp_d   = ch_exp_q;
		first_d    = first_q;
		status_d   = status_q;
		next_d     = next_q;
		clr_d      = clr_q;
		heap_re    = 1'b0;
		heap_raddr = '0;
		heap_we    = 1'b0;
		heap_waddr = hole_q;
		heap_wdata = {e_exp_q, e_id_q};
		slot_re    = 1'b0;
		slot_raddr = IW'(in_id);
		slot_we    = 1'b0;
		slot_waddr = IW'(e_id_q);
		slot_wdata = hole_q;
		res_valid  = 1'b0;
		res        = '0;

		case (state_q)
			S_CLR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				slot_wdata = '0;
				clr_d      = clr_q + IW'(1);
				if (clr_q == IW'(ID_SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					mode_d     = mode_t'(s_tuser);
					id_d       = in_id;
					exp_d      = in_exp;
					now_d      = now_sat;
					in_range_d = (32'(in_id) < 32'(ID_SLOTS));
					status_d   = STAT_OK;
					next_d     = '0;
					slot_re    = 1'b1;
					state_d    = S_LOOK;
				end
			end
			S_LOOK: begin
				hole_d     = slot_rd_q;
				heap_re    = 1'b1;
				heap_raddr = slot_rd_q;
				state_d    = S_CHK;
			end
			S_CHK: begin
				e_id_d  = id_q;
				e_exp_d = exp_q;
				first_d = 1'b1;
				case (mode_q)
					MODE_ADD: begin
						if (!in_range_q) begin
							status_d = STAT_NOID;
							state_d  = S_FIN;
						end else if (present) begin
							state_d = S_DN0;
						end else if (cnt_q == CW'(HEAP_CAPACITY)) begin
							status_d = STAT_FULL;
							state_d  = S_FIN;
						end else begin
							hole_d  = SW'(cnt_q);
							cnt_d   = cnt_q + CW'(1);
							state_d = S_UP0;
						end
					end
					MODE_ADJUST: begin
						if (!present) begin
							status_d = STAT_NOID;
							state_d  = S_FIN;
						end else begin
							state_d = S_DN0;
						end
					end
					MODE_FIRE: begin
						if (!present) begin
							status_d = STAT_NOID;
							state_d  = S_FIN;
						end else begin
							state_d = S_FIRE;
						end
					end
					MODE_DROP: begin
						if (cnt_q == '0) begin
							status_d = STAT_NOID;
							state_d  = S_FIN;
						end else begin
							hole_d  = '0;
							state_d = S_RM0;
						end
					end
					MODE_TICK, MODE_QUERY: begin
						state_d = S_TK0;
					end
					MODE_CLEAR: begin
						cnt_d   = '0;
						state_d = S_FIN;
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_FIRE: begin
				res.fired_id = id_q;
				if (res_ready) begin
					res_valid = 1'b1;
					state_d   = S_RM0;
				end
			end
			S_RM0: begin
				cnt_d = last_slot;
				if (CW'(hole_q) == last_slot) begin
					state_d = tick_mode ? S_TK0 : S_FIN;
				end else begin
					heap_re    = 1'b1;
					heap_raddr = SW'(last_slot);
					state_d    = S_RM1;
				end
			end
			S_RM1: begin
				e_id_d  = rd_id;
				e_exp_d = rd_exp;
				first_d = 1'b1;
				state_d = S_DN0;
			end
			S_DN0: begin
				if (child_l >= cnt_x) begin
					if (first_q) begin
						state_d = S_UP0;
					end else begin
						heap_we = 1'b1;
						slot_we = 1'b1;
						state_d = tick_mode ? S_TK0 : S_FIN;
					end
				end else begin
					heap_re    = 1'b1;
					heap_raddr = SW'(child_l);
					state_d    = S_DN1;
				end
			end
			S_DN1: begin
				ch_id_d  = rd_id;
				ch_exp_d = rd_exp;
				ch_idx_d = SW'(child_l);
				if (child_r < cnt_x) begin
					heap_re    = 1'b1;
					heap_raddr = SW'(child_r);
					state_d    = S_DN2;
				end else begin
					state_d = S_DN3;
				end
			end
			S_DN2: begin
				// The right child wins only when strictly earlier.
				if (rd_exp < ch_exp_q) begin
					ch_id_d  = rd_id;
					ch_exp_d = rd_exp;
					ch_idx_d = SW'(child_r);
				end
				state_d = S_DN3;
			end
			S_DN3: begin
				if (ch_exp_q < e_exp_q) begin
					heap_we    = 1'b1;
					heap_wdata = {ch_exp_q, ch_id_q};
					slot_we    = 1'b1;
					slot_waddr = IW'(ch_id_q);
					hole_d     = ch_idx_q;
					first_d    = 1'b0;
					state_d    = S_DN0;
				end else if (first_q) begin
					state_d = S_UP0;
				end else begin
					heap_we = 1'b1;
					slot_we = 1'b1;
					state_d = tick_mode ? S_TK0 : S_FIN;
				end
			end
			S_UP0: begin
				if (hole_q == '0) begin
					heap_we = 1'b1;
					slot_we = 1'b1;
					state_d = tick_mode ? S_TK0 : S_FIN;
				end else begin
					heap_re    = 1'b1;
					heap_raddr = parent;
					state_d    = S_UP1;
				end
			end
			S_UP1: begin
				if (e_exp_q < rd_exp) begin
					heap_we    = 1'b1;
					heap_wdata = heap_rd_q;
					slot_we    = 1'b1;
					slot_waddr = IW'(rd_id);
					hole_d     = parent;
					state_d    = S_UP0;
				end else begin
					heap_we = 1'b1;
					slot_we = 1'b1;
					state_d = tick_mode ? S_TK0 : S_FIN;
				end
			end
			S_TK0: begin
				if (cnt_q == '0) begin
					if (mode_q == MODE_QUERY) begin
						next_d = '1;
					end
					state_d = S_FIN;
				end else begin
					heap_re    = 1'b1;
					heap_raddr = '0;
					state_d    = S_TK1;
				end
			end
			S_TK1: begin
				res.fired_id = rd_id;
				if (rd_exp <= now_q) begin
					if (res_ready) begin
						res_valid = 1'b1;
						hole_d    = '0;
						state_d   = S_RM0;
					end
				end else begin
					if (mode_q == MODE_QUERY) begin
						next_d = (|diff[TB-1:31]) ? 32'h7FFF_FFFF : {1'b0, diff[30:0]};
					end
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				res.kind         = 1'b1;
				res.next_tick_ms = next_q;
				res.status       = status_q;
				res.last         = 1'b1;
				if (res_ready) begin
					res_valid = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q     <= mode_d;
		id_q       <= id_d;
		exp_q      <= exp_d;
		now_q      <= now_d;
		in_range_q <= in_range_d;
		hole_q     <= hole_d;
		ch_idx_q   <= ch_idx_d;
		e_id_q     <= e_id_d;
		e_exp_q    <= e_exp_d;
		ch_id_q    <= ch_id_d;
		ch_exp_q   <= ch_exp_d;
		first_q    <= first_d;
		status_q   <= status_d;
		next_q     <= next_d;
	end

	// Heap memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (heap_we) begin
			heap_mem[heap_waddr] <= heap_wdata;
		end
		if (heap_re) begin
			heap_rd_q <= heap_mem[heap_raddr];
		end
	end

	// Id map: a map entry only counts when the heap slot it names holds that id,
	// so removals and clears never have to touch it.
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_raddr];
		end
	end

	tmq_out_slice u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {4'b0000, out_res.status, out_res.next_tick_ms, out_res.fired_id};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule

// ===== hdl/tmq_checker.sv =====
// ----------------------------------------------------------------------------
// Timer queue port checker
// Watches the top-level ports for result framing and handshake rules.
// ----------------------------------------------------------------------------
module tmq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// A stalled result word stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// Fired words never close an item and carry no status or remaining time.
	a_fired: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tlast && (m_tdata[43:10] == 34'd0))
		else $error("fired word carries status fields");

	// Status words always close the item.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata[9:0] == 10'd0))
		else $error("status word without last");

	// The block works on one item at a time.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

endmodule

bind min_heap_timer_queue tmq_checker u_tmq_checker (.*);

// ===== dv/min_heap_timer_queue_test.sv =====
// ----------------------------------------------------------------------------
// Min-heap timer queue testbench
// Drives timer commands into the queue, predicts every fired and status word
// from a behavioral heap kept in the testbench, and checks each result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_heap_timer_queue_test;
	import tmq_pkg::*;

	localparam int CAP = 32;
	localparam int NIDS = 1024;
	localparam longint unsigned TMAX = (64'd1 << 48) - 1;
	localparam int WATCH_LIMIT = 4000;

	// One expected result word.
	typedef struct {
		logic        kind;
		logic [9:0]  fired_id;
		logic [31:0] next_tick_ms;
		logic [1:0]  status;
		logic        last;
	} res_word_t;

	// Behavioral timer heap: predicts the words caused by each command.
	class timer_scoreboard;
		int unsigned     hid[CAP];
		longint unsigned hexp[CAP];
		bit              id_live[NIDS];
		int unsigned     id_slot[NIDS];
		int unsigned     count;
		res_word_t       pending[$];
		int              errors;

		function void clear_all();
			foreach (id_live[i]) id_live[i] = 0;
			count = 0;
		endfunction

		function void swap(int unsigned a, int unsigned b);
			int unsigned ti;
			longint unsigned te;
			ti = hid[a]; te = hexp[a];
			hid[a] = hid[b]; hexp[a] = hexp[b];
			hid[b] = ti; hexp[b] = te;
			id_slot[hid[a]] = a;
			id_slot[hid[b]] = b;
		endfunction

		function int unsigned up(int unsigned i);
			int unsigned p;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (!(hexp[i] < hexp[p])) break;
				swap(i, p);
				i = p;
			end
			return i;
		endfunction

		function int unsigned down(int unsigned i, int unsigned n);
			int unsigned c;
			forever begin
				c = 2 * i + 1;
				if (c >= n) break;
				if (c + 1 < n && hexp[c + 1] < hexp[c]) c++;
				if (!(hexp[c] < hexp[i])) break;
				swap(i, c);
				i = c;
			end
			return i;
		endfunction

		function void resettle(int unsigned i);
			if (down(i, count) == i) void'(up(i));
		endfunction

		function void remove(int unsigned i);
			int unsigned n, gone;
			n = count - 1;
			gone = hid[i];
			if (i < n) begin
				swap(i, n);
				gone = hid[n];
				count = n;
				resettle(i);
			end
			id_live[gone] = 0;
			count = n;
		endfunction

		function void push(logic kind, logic [9:0] id, logic [31:0] nxt,
				logic [1:0] st, logic lst);
			res_word_t r;
			r.kind = kind; r.fired_id = id; r.next_tick_ms = nxt;
			r.status = st; r.last = lst;
			pending = {pending, r};
		endfunction

		function void expire(longint unsigned now);
			while (count > 0 && hexp[0] <= now) begin
				push(1'b0, 10'(hid[0]), '0, STAT_OK, 1'b0);
				remove(0);
			end
		endfunction

		// Notes one accepted command and queues the words it must produce.
		function void note_command(mode_t mode, logic [9:0] id, logic [30:0] tmo,
				logic [47:0] now);
			longint unsigned expiry, d;
			logic [31:0] nxt;
			status_t st;
			int unsigned s;
			nxt = '0;
			st = STAT_OK;
			// The sum cannot exceed 64 bits, so saturation is a plain compare.
			expiry = longint'(now) + longint'(tmo);
			if (expiry > TMAX) expiry = TMAX;
			case (mode)
				MODE_ADD: begin
					if (id_live[id]) begin
						hexp[id_slot[id]] = expiry;
						resettle(id_slot[id]);
					end else if (count >= CAP) begin
						st = STAT_FULL;
					end else begin
						s = count++;
						hid[s] = id; hexp[s] = expiry;
						id_live[id] = 1; id_slot[id] = s;
						void'(up(s));
					end
				end
				MODE_ADJUST: begin
					if (!id_live[id]) st = STAT_NOID;
					else begin
						hexp[id_slot[id]] = expiry;
						resettle(id_slot[id]);
					end
				end
				MODE_FIRE: begin
					if (!id_live[id]) st = STAT_NOID;
					else begin
						push(1'b0, id, '0, STAT_OK, 1'b0);
						remove(id_slot[id]);
					end
				end
				MODE_DROP: begin
					if (count == 0) st = STAT_NOID;
					else remove(0);
				end
				MODE_TICK: expire(now);
				MODE_CLEAR: clear_all();
				MODE_QUERY: begin
					expire(now);
					if (count == 0) nxt = 32'hFFFF_FFFF;
					else begin
						d = hexp[0] - now;
						nxt = (d > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : d[31:0];
					end
				end
				default: ;
			endcase
			push(1'b1, '0, nxt, st, 1'b1);
		endfunction

		// Compares one result word against the oldest expectation.
		function void check_word(logic kind, logic [9:0] id, logic [31:0] nxt,
				logic [1:0] st, logic lst);
			res_word_t e;
			if (pending.size() == 0) begin
				$error("unexpected result word kind=%0d id=%0d", kind, id);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (kind !== e.kind) begin
				$error("kind: expected %0d, got %0d", e.kind, kind); errors++;
			end
			if (id !== e.fired_id) begin
				$error("fired_id: expected %0d, got %0d", e.fired_id, id); errors++;
			end
			if (nxt !== e.next_tick_ms) begin
				$error("next_tick_ms: expected %0d, got %0d",
					$signed(e.next_tick_ms), $signed(nxt));
				errors++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st); errors++;
			end
			if (lst !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, lst); errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;   // timer_id[9:0], timeout_ms[40:10], now_ms[88:41]
	logic [2:0]  s_tuser;   // mode[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // fired_id[9:0], next_tick_ms[41:10], status[43:42]
	logic        m_tuser;   // kind[0]
	logic        m_tlast;

	timer_scoreboard sb;
	bit          calm;      // no idling on either side in the closing part
	int          quiet_cycles;
	logic [47:0] clock_ms;  // monotonic current time fed to the block
	int unsigned ids[8];    // small id pool so that commands hit live timers

	min_heap_timer_queue i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: random stall bursts, and every accepted word is checked.
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_word(m_tuser, m_tdata[9:0], m_tdata[41:10], m_tdata[43:42],
					m_tlast);
			if (gap > 0 && !calm) begin
				gap--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 9) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: counts cycles in which no word moves on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCH_LIMIT) begin
			$display("[min_heap_timer_queue] ERROR");
			$finish;
		end
	end

	// Sends one command and waits for it to be accepted. In the random part
	// the caller advances the clock value beforehand so that time never runs
	// backward. The word stays on the bus after acceptance until the next
	// command, an idle gap or the drain replaces it; the block is busy by then.
	task automatic send(mode_t mode, logic [9:0] id, logic [30:0] tmo, logic [47:0] now);
		if (!calm && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 9)) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {7'd0, now, tmo, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_command(mode, id, tmo, now);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [30:0] rand_tmo();
		case ($urandom_range(0, 5))
			0: return 31'd0;
			1: return 31'h7FFF_FFFF;
			2: return 31'($urandom);
			default: return 31'($urandom_range(0, 200));
		endcase
	endfunction

	// Advances the monotonic clock by a small step, or a rare large jump.
	task automatic step_time();
		if ($urandom_range(0, 30) == 0) clock_ms = clock_ms + {8'h0, $urandom, 8'h0};
		else clock_ms = clock_ms + $urandom_range(0, 40);
	endtask

	initial begin
		mode_t m;
		sb = new();
		sb.clear_all();
		calm = 0;
		clock_ms = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_ADD;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty-heap corner cases, then fill to capacity.
		send(MODE_DROP, 10'd0, 31'd0, 48'd0);
		send(MODE_QUERY, 10'd0, 31'd0, 48'd0);
		send(MODE_FIRE, 10'd1023, 31'd0, 48'd0);
		send(MODE_ADJUST, 10'd5, 31'd3, 48'd0);
		send(mode_t'(3'd7), 10'h3FF, 31'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send(MODE_ADD, 10'd1023, 31'h7FFF_FFFF, 48'd0);
		send(MODE_ADD, 10'd7, 31'd50, 48'd0);
		send(MODE_ADD, 10'd7, 31'd5, 48'd0);      // restart of a live id
		send(MODE_ADJUST, 10'd1023, 31'd1, 48'd0);
		send(MODE_QUERY, 10'd0, 31'd0, 48'd2);
		send(MODE_FIRE, 10'd7, 31'd0, 48'd2);
		for (int i = 0; i < CAP; i++) send(MODE_ADD, 10'(100 + i), 31'($urandom_range(0, 30)), 48'd2);
		send(MODE_ADD, 10'd999, 31'd1, 48'd2);    // heap full
		send(MODE_DROP, 10'd0, 31'd0, 48'd2);
		send(MODE_TICK, 10'd0, 31'd0, 48'd20);
		send(MODE_CLEAR, 10'd0, 31'd0, 48'd20);
		send(MODE_ADD, 10'd3, 31'h7FFF_FFFF, 48'hFFFF_FFFF_FFF0); // saturating sum
		send(MODE_QUERY, 10'd0, 31'd0, 48'hFFFF_FFFF_FFF0);
		send(MODE_TICK, 10'd0, 31'd0, 48'hFFFF_FFFF_FFFF);
		clock_ms = 0;
		send(MODE_CLEAR, 10'd0, 31'd0, 48'd0);
		drain(); // sender holds off until every result has arrived

		// Random part: all modes mixed, adds most often, mostly on a small id pool.
		for (int i = 0; i < 8; i++) ids[i] = $urandom_range(0, 1023);
		for (int n = 0; n < 400; n++) begin
			if (n == 340) calm = 1;
			if ($urandom_range(0, 60) == 0) ids[$urandom_range(0, 7)] = $urandom_range(0, 1023);
			step_time();
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6: m = MODE_ADD;
				7, 8: m = MODE_ADJUST;
				9, 10: m = MODE_FIRE;
				11: m = MODE_DROP;
				12, 13, 14: m = MODE_TICK;
				15, 16: m = MODE_QUERY;
				17: m = ($urandom_range(0, 3) == 0) ? MODE_CLEAR : MODE_TICK;
				default: m = mode_t'($urandom_range(0, 7));
			endcase
			if (m == MODE_ADD && $urandom_range(0, 3) == 0)
				send(m, 10'($urandom_range(0, 1023)), rand_tmo(), clock_ms);
			else
				send(m, 10'(ids[$urandom_range(0, 7)] + $urandom_range(0, 40)), rand_tmo(),
					clock_ms);
		end

		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[min_heap_timer_queue] OK");
		else
			$display("[min_heap_timer_queue] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tmq_pkg.sv
hdl/tmq_out_slice.sv
hdl/min_heap_timer_queue.sv
hdl/tmq_checker.sv
dv/min_heap_timer_queue_test.sv
